// ===== rtl/pi_bc_pkg.sv =====
`timescale 1ns / 1ps

package pi_bc_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DATA_W        = 32;
  localparam int GAIN_W        = 31;
  localparam int PC_W          = 3;
  localparam int CFG_ADDR_W    = 3;

  localparam logic signed [DATA_W-1:0] LOWER_RESET = -32'sd65536;
  localparam logic signed [DATA_W-1:0] UPPER_RESET = 32'sd65536;
  localparam logic [GAIN_W-1:0]        STEP_RESET  = 31'd66;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_LOWER_LIMIT = 3'd2,
    REG_UPPER_LIMIT = 3'd3,
    REG_WINDUP_GAIN = 3'd4,
    REG_STEP_TIME   = 3'd5
  } cfg_reg_t;

  // multiplier operand selects
  typedef enum logic [1:0] {MA_KI, MA_KP, MA_AW, MA_FM} mul_a_t;
  typedef enum logic [1:0] {MB_X, MB_DT, MB_T} mul_b_t;

  // adder / clamp operations
  typedef enum logic [1:0] {ALU_NOP, ALU_INTEG, ALU_RAW, ALU_DIFF} alu_op_t;

  // sequencing
  typedef enum logic [1:0] {SQ_NEXT, SQ_BR_FB, SQ_END} seq_op_t;

  typedef struct packed {
    logic            mul_en;
    mul_a_t          mul_a;
    mul_b_t          mul_b;
    alu_op_t         alu;
    seq_op_t         seq;
    logic [PC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic    exec;
    logic    emit;
    logic    mul_en;
    mul_a_t  mul_a;
    mul_b_t  mul_b;
    alu_op_t alu;
  } ctrl_t;

  // Control store. Update runs steps 0..3, feedback branches from 0 to 4..7.
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      3'd0: w = '{1'b1, MA_KI, MB_X,  ALU_NOP,   SQ_BR_FB, 3'd4};
      3'd1: w = '{1'b1, MA_FM, MB_DT, ALU_NOP,   SQ_NEXT,  3'd0};
      3'd2: w = '{1'b1, MA_KP, MB_X,  ALU_INTEG, SQ_NEXT,  3'd0};
      3'd3: w = '{1'b0, MA_KI, MB_X,  ALU_RAW,   SQ_END,   3'd0};
      3'd4: w = '{1'b0, MA_KI, MB_X,  ALU_DIFF,  SQ_NEXT,  3'd0};
      3'd5: w = '{1'b1, MA_AW, MB_T,  ALU_NOP,   SQ_NEXT,  3'd0};
      3'd6: w = '{1'b1, MA_FM, MB_DT, ALU_NOP,   SQ_NEXT,  3'd0};
      3'd7: w = '{1'b0, MA_KI, MB_X,  ALU_INTEG, SQ_END,   3'd0};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/pi_controller_back_calc_antiwindup.sv =====
`timescale 1ns / 1ps
// The microcode steps through a single shared 32x32 multiplier, at most one product per step;
// an update runs steps 0..3, feedback steps 0 and 4..7. No new item is taken while one is
// in flight: s_axis_tready stays low until the final step of the current item has run.
// A result waiting at the output stalls only the final step of the next item.
// Reset (synchronous, rst high): integrator and history cleared, registers to defaults.

module pi_controller_back_calc_antiwindup #(
  parameter int FRAC_BITS = pi_bc_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [31:0]                          s_axis_tdata,  // sample_value
  input  logic                                 s_axis_tuser,  // action
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [63:0]                          m_axis_tdata,  // drive_out, raw_out
  output logic                                 m_axis_tuser,  // limited
  input  logic                                 cfg_we,
  input  logic [pi_bc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [31:0]                          cfg_data
);

  logic [pi_bc_pkg::GAIN_W-1:0]        prop_gain, integ_gain, windup_gain, step_time;
  logic signed [pi_bc_pkg::DATA_W-1:0] lower_limit, upper_limit;
  logic signed [pi_bc_pkg::DATA_W-1:0] res_drive, res_raw;

  logic             busy, in_accept, out_hold;
  pi_bc_pkg::ctrl_t ctrl;

  assign s_axis_tready = !busy;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_hold      = m_axis_tvalid && !m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain   <= '0;
      integ_gain  <= '0;
      lower_limit <= pi_bc_pkg::LOWER_RESET;
      upper_limit <= pi_bc_pkg::UPPER_RESET;
      windup_gain <= '0;
      step_time   <= pi_bc_pkg::STEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        pi_bc_pkg::REG_PROP_GAIN:   prop_gain   <= cfg_data[pi_bc_pkg::GAIN_W-1:0];
        pi_bc_pkg::REG_INTEG_GAIN:  integ_gain  <= cfg_data[pi_bc_pkg::GAIN_W-1:0];
        pi_bc_pkg::REG_LOWER_LIMIT: lower_limit <= cfg_data;
        pi_bc_pkg::REG_UPPER_LIMIT: upper_limit <= cfg_data;
        pi_bc_pkg::REG_WINDUP_GAIN: windup_gain <= cfg_data[pi_bc_pkg::GAIN_W-1:0];
        pi_bc_pkg::REG_STEP_TIME:   step_time   <= cfg_data[pi_bc_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  pi_bc_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .in_action (s_axis_tuser),
    .out_hold  (out_hold),
    .busy      (busy),
    .ctrl      (ctrl)
  );

  pi_bc_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .in_accept    (in_accept),
    .sample_value (s_axis_tdata),
    .prop_gain    (prop_gain),
    .integ_gain   (integ_gain),
    .windup_gain  (windup_gain),
    .step_time    (step_time),
    .lower_limit  (lower_limit),
    .upper_limit  (upper_limit),
    .res_drive    (res_drive),
    .res_raw      (res_raw)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ctrl.exec && ctrl.emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec && ctrl.emit) begin
      m_axis_tdata <= {res_raw, res_drive};
      m_axis_tuser <= (res_drive != res_raw);
    end
  end

endmodule

// ===== rtl/pi_bc_seq.sv =====
`timescale 1ns / 1ps

module pi_bc_seq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_accept,
  input  logic                  in_action,
  input  logic                  out_hold,
  output logic                  busy,
  output pi_bc_pkg::ctrl_t      ctrl
);

  logic [pi_bc_pkg::PC_W-1:0] pc, pc_next;
  logic                       busy_next;
  logic                       action;
  pi_bc_pkg::ucode_t          uw;

  always_comb begin
    uw          = pi_bc_pkg::ucode_rom(pc);
    ctrl.emit   = (uw.seq == pi_bc_pkg::SQ_END);
    // final step waits while the previous result is still unclaimed
    ctrl.exec   = busy && !(ctrl.emit && out_hold);
    ctrl.mul_en = uw.mul_en;
    ctrl.mul_a  = uw.mul_a;
    ctrl.mul_b  = uw.mul_b;
    ctrl.alu    = uw.alu;

    pc_next   = pc;
    busy_next = busy;
    if (in_accept) begin
      pc_next   = '0;
      busy_next = 1'b1;
    end else if (ctrl.exec) begin
      unique case (uw.seq)
        pi_bc_pkg::SQ_NEXT:  pc_next = pc + 1'b1;
        pi_bc_pkg::SQ_BR_FB: pc_next = action ? uw.target : pc + 1'b1;
        pi_bc_pkg::SQ_END:   busy_next = 1'b0;
        default:             busy_next = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= '0;
      busy <= 1'b0;
    end else begin
      pc   <= pc_next;
      busy <= busy_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      action <= in_action;
    end
  end

endmodule

// ===== rtl/pi_bc_dp.sv =====
`timescale 1ns / 1ps

module pi_bc_dp #(
  parameter int FRAC_BITS = pi_bc_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  pi_bc_pkg::ctrl_t                       ctrl,
  input  logic                                   in_accept,
  input  logic signed [pi_bc_pkg::DATA_W-1:0]    sample_value,
  input  logic [pi_bc_pkg::GAIN_W-1:0]           prop_gain,
  input  logic [pi_bc_pkg::GAIN_W-1:0]           integ_gain,
  input  logic [pi_bc_pkg::GAIN_W-1:0]           windup_gain,
  input  logic [pi_bc_pkg::GAIN_W-1:0]           step_time,
  input  logic signed [pi_bc_pkg::DATA_W-1:0]    lower_limit,
  input  logic signed [pi_bc_pkg::DATA_W-1:0]    upper_limit,
  output logic signed [pi_bc_pkg::DATA_W-1:0]    res_drive,
  output logic signed [pi_bc_pkg::DATA_W-1:0]    res_raw
);

  localparam int W  = pi_bc_pkg::DATA_W;
  localparam int PW = 2 * W;

  localparam logic signed [PW-1:0] SAT_MAX = PW'({1'b0, {(W-1){1'b1}}});
  localparam logic signed [PW-1:0] SAT_MIN = -SAT_MAX - PW'(1);

  logic signed [W-1:0]  x, t, integ, raw, outl;
  logic signed [PW-1:0] p;

  logic signed [PW-1:0] sh, prod;
  logic signed [W-1:0]  fm, opa, opb, cx, ssum, cl;
  logic signed [W:0]    sum;

  function automatic logic signed [W-1:0] clamp(input logic signed [W-1:0] v,
                                                 input logic signed [W-1:0] lo,
                                                 input logic signed [W-1:0] hi);
    logic signed [W-1:0] r;
    if (v < lo) r = lo;
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

  always_comb begin
    // arithmetic shift is floor rounding; then saturate to 32 bits
    sh = p >>> FRAC_BITS;
    if (sh > SAT_MAX) fm = SAT_MAX[W-1:0];
    else if (sh < SAT_MIN) fm = SAT_MIN[W-1:0];
    else fm = sh[W-1:0];

    unique case (ctrl.mul_a)
      pi_bc_pkg::MA_KI: opa = {1'b0, integ_gain};
      pi_bc_pkg::MA_KP: opa = {1'b0, prop_gain};
      pi_bc_pkg::MA_AW: opa = {1'b0, windup_gain};
      pi_bc_pkg::MA_FM: opa = fm;
      default:          opa = fm;
    endcase
    unique case (ctrl.mul_b)
      pi_bc_pkg::MB_X:  opb = x;
      pi_bc_pkg::MB_DT: opb = {1'b0, step_time};
      pi_bc_pkg::MB_T:  opb = t;
      default:          opb = x;
    endcase
    prod = PW'(opa) * PW'(opb);

    cx = clamp(x, lower_limit, upper_limit);
    if (ctrl.alu == pi_bc_pkg::ALU_DIFF) sum = (W+1)'(cx) - (W+1)'(raw);
    else sum = (W+1)'(integ) + (W+1)'(fm);
    if (sum[W] != sum[W-1]) ssum = sum[W] ? SAT_MIN[W-1:0] : SAT_MAX[W-1:0];
    else ssum = sum[W-1:0];
    cl = clamp(ssum, lower_limit, upper_limit);

    if (ctrl.alu == pi_bc_pkg::ALU_RAW) begin
      res_drive = cl;
      res_raw   = ssum;
    end else begin
      res_drive = outl;
      res_raw   = raw;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      x <= sample_value;
    end
    if (ctrl.exec && ctrl.mul_en) begin
      p <= prod;
    end
    if (ctrl.exec && ctrl.alu == pi_bc_pkg::ALU_DIFF) begin
      t <= ssum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ <= '0;
      raw   <= '0;
      outl  <= '0;
    end else if (ctrl.exec) begin
      unique case (ctrl.alu)
        pi_bc_pkg::ALU_NOP: ;
        pi_bc_pkg::ALU_INTEG: integ <= cl;
        pi_bc_pkg::ALU_RAW: begin
          raw  <= ssum;
          outl <= cl;
        end
        pi_bc_pkg::ALU_DIFF: outl <= cx;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/pi_bc_checker.sv =====
`timescale 1ns / 1ps

module pi_bc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // result held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // one item in flight: no new transaction straight after acceptance
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

  // no result can appear the cycle after an item enters an empty block
  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result too early");

  // limited flag matches the two values it compares
  a_limited: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser == (m_axis_tdata[31:0] != m_axis_tdata[63:32]))
    else $error("limited flag inconsistent");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("bad state after reset");

endmodule

bind pi_controller_back_calc_antiwindup pi_bc_checker u_pi_bc_checker (.*);
